// ===== hw/rtl/tmf_pkg.sv =====
// Shared types and constants of the thermal mass flow calculator.
`timescale 1ns / 1ps
package tmf_pkg;

  // Kelvin offset in Q8.8 and the cubic heat capacity fit with 40 fraction bits.
  localparam logic [16:0] KELVIN_OFFSET = 17'd69926;
  localparam logic [12:0] CP_C3         = 13'd4544;
  localparam logic [18:0] CP_C2         = 19'd355248;
  localparam logic [25:0] CP_C1         = 26'd51714804;
  localparam logic [43:0] CP_C0         = 44'd1090439004776;
  localparam logic [43:0] CP_HALF       = 44'd33554432;

  localparam int POWER_W = 23;
  localparam int DBAND_W = 13;
  localparam int MAG_W   = 16;
  localparam int CP_W    = 16;
  localparam int DEN_W   = 32;
  localparam int NUM_W   = 42;
  localparam int QUO_W   = 21;
  localparam int REM_W   = 53;
  localparam int FLOW_W  = 20;

  localparam logic [QUO_W-1:0] FLOW_POS_MAX = 21'd524287;
  localparam logic [QUO_W-1:0] FLOW_NEG_MAX = 21'd524288;

  localparam logic [POWER_W-1:0] POWER_RESET  = 23'd312017;
  localparam logic [DBAND_W-1:0] DBAND_RESET  = 13'd512;

  // Configuration register indexes.
  localparam logic [0:0] REG_HEATER_POWER = 1'b0;
  localparam logic [0:0] REG_DEADBAND     = 1'b1;

  // Per-request sideband that travels beside the arithmetic.
  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [MAG_W-1:0] mag;
  } side_t;

  // One stage of the restoring divider.
  typedef struct packed {
    side_t            side;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

endpackage

// ===== hw/rtl/tmf_if.sv =====
// Valid/ready channel interfaces for temperature requests and flow results.
`timescale 1ns / 1ps
interface tmf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] upstream_temp;
  logic signed [15:0] downstream_temp;

  modport source (output valid, output upstream_temp, output downstream_temp, input ready);
  modport sink   (input valid, input upstream_temp, input downstream_temp, output ready);
endinterface

interface tmf_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] mass_flow;
  logic               zero_flow;
  logic               saturated;

  modport source (output valid, output mass_flow, output zero_flow, output saturated,
                  input ready);
  modport sink   (input valid, input mass_flow, input zero_flow, input saturated,
                  output ready);
endinterface

// ===== hw/rtl/tmf_poly.sv =====
// Four-stage pipeline that evaluates the cubic heat capacity fit.
`timescale 1ns / 1ps
module tmf_poly
  import tmf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [16:0]     in_x,
  input  side_t           in_side,
  output logic            out_vld,
  output logic [CP_W-1:0] out_cp,
  output side_t           out_side
);

  logic [3:0]  vld_r;
  side_t       side_r [4];

  logic [16:0] p1_x_r;
  logic [33:0] p1_x2_r;
  logic [34:0] p1_t1_r;
  logic [50:0] p2_x3_r;
  logic [36:0] p2_t2_r;
  logic [34:0] p2_t1_r;
  logic [34:0] p3_t3_r;
  logic [36:0] p3_t2_r;
  logic [34:0] p3_t1_r;
  logic [CP_W-1:0] p4_cp_r;

  logic [42:0] t1_prod;
  logic [52:0] t2_prod;
  logic [63:0] t3_prod;
  logic [43:0] cp_sum;

  assign t1_prod = 43'(in_x) * 43'(CP_C1);
  assign t2_prod = 53'(p1_x2_r) * 53'(CP_C2);
  assign t3_prod = 64'(p2_x3_r) * 64'(CP_C3);
  assign cp_sum  = CP_C0 + 44'(p3_t2_r) - 44'(p3_t1_r) - 44'(p3_t3_r) + CP_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= side_r[2];
      p1_x_r    <= in_x;
      p1_x2_r   <= 34'(in_x) * 34'(in_x);
      p1_t1_r   <= t1_prod[42:8];
      p2_x3_r   <= 51'(p1_x2_r) * 51'(p1_x_r);
      p2_t2_r   <= t2_prod[52:16];
      p2_t1_r   <= p1_t1_r;
      p3_t3_r   <= t3_prod[63:29];
      p3_t2_r   <= p2_t2_r;
      p3_t1_r   <= p2_t1_r;
      p4_cp_r   <= cp_sum[41:26];
    end
  end

  assign out_vld  = vld_r[3];
  assign out_cp   = p4_cp_r;
  assign out_side = side_r[3];

endmodule

// ===== hw/rtl/tmf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module tmf_div
  import tmf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [POWER_W-1:0] in_power,
  input  side_t              in_side,
  output logic               out_vld,
  output logic [QUO_W-1:0]   out_quo,
  output logic               out_ovf,
  output side_t              out_side
);

  logic               a_vld_r;
  side_t              a_side_r;
  logic [DEN_W-1:0]   a_den_r;
  logic [NUM_W-1:0]   a_num_r;

  logic [QUO_W:0]     vld_r;
  div_stage_t         st_r [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_vld;
      vld_r[0] <= a_vld_r;
    end
  end

  // Rounded numerator, then the check whether the quotient needs more than QUO_W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r      <= in_side;
      a_den_r       <= in_den;
      a_num_r       <= NUM_W'({in_power, 18'd0}) + NUM_W'(in_den >> 1);
      st_r[0].side  <= a_side_r;
      st_r[0].den   <= a_den_r;
      st_r[0].rem   <= REM_W'(a_num_r);
      st_r[0].quo   <= '0;
      st_r[0].ovf   <= REM_W'(a_num_r) >= (REM_W'(a_den_r) << QUO_W);
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int BIT = QUO_W - 1 - i;
    logic [REM_W-1:0] shifted;
    logic             take;
    div_stage_t       nxt;

    assign shifted = REM_W'(st_r[i].den) << BIT;
    assign take    = st_r[i].rem >= shifted;

    always_comb begin
      nxt          = st_r[i];
      nxt.quo[BIT] = take;
      if (take) begin
        nxt.rem = st_r[i].rem - shifted;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1] <= nxt;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W];
  assign out_quo  = st_r[QUO_W].quo;
  assign out_ovf  = st_r[QUO_W].ovf;
  assign out_side = st_r[QUO_W].side;

endmodule

// ===== hw/rtl/thermal_mass_flow_calc.sv =====
// Top level of the thermal mass flow calculator: front end, pipelines and output buffer.
`timescale 1ns / 1ps
// The block takes one request per cycle while the output buffer has room, an upstream
// and a downstream temperature in signed Q8.8 Celsius, and returns one result per
// request: the mass flow in signed Q8.12, heater power over heat capacity times
// temperature difference, with the sign of the difference. Heat capacity comes from a
// cubic fit in the upstream temperature in kelvin. A difference at or below the
// deadband gives zero flow with zero_flow set; a quotient beyond the 20-bit range is
// clipped with saturated set. The front-end stage loads at the accepting edge. After it
// come four stages for the polynomial, one for the denominator product, two for the
// numerator and the overflow check, and 21 for the divider, which retires one quotient
// bit per stage. The output register, or the skid entry while the result channel
// refuses a result, then loads from the last divider stage. Throughput is one request
// per cycle while the output buffer has room. A two-entry output buffer decouples the
// ready of the input from the ready of the result channel, so the input only stalls
// after the result channel has refused a result. Configuration writes take effect at
// once and are meant to happen while no request is in flight.
module thermal_mass_flow_calc
  import tmf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  tmf_in_if.sink             in_ch,
  tmf_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [POWER_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [POWER_W-1:0] power_r;
  logic [DBAND_W-1:0] dband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= POWER_RESET;
      dband_r <= DBAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEATER_POWER: power_r <= cfg_wdata;
        REG_DEADBAND:     dband_r <= cfg_wdata[DBAND_W-1:0];
        default:          ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output buffer has room.
  logic en;
  logic skid_vld_r;
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  // Front end: kelvin conversion, difference magnitude and the deadband test.
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic               f_vld_r;
  logic [16:0]        f_x_r;
  side_t              f_side_r;

  assign diff     = 17'(in_ch.upstream_temp) - 17'(in_ch.downstream_temp);
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_x_r         <= 17'(18'(in_ch.upstream_temp) + 18'(KELVIN_OFFSET));
      f_side_r.neg  <= diff[16];
      f_side_r.mag  <= diff_abs[MAG_W-1:0];
      f_side_r.zero <= diff_abs <= 17'(dband_r);
    end
  end

  // Heat capacity in Q2.14.
  logic            p_vld;
  logic [CP_W-1:0] p_cp;
  side_t           p_side;

  tmf_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld_r),
    .in_x     (f_x_r),
    .in_side  (f_side_r),
    .out_vld  (p_vld),
    .out_cp   (p_cp),
    .out_side (p_side)
  );

  // Denominator: heat capacity times the difference magnitude.
  logic             d_vld_r;
  logic [DEN_W-1:0] d_den_r;
  side_t            d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_den_r  <= DEN_W'(p_cp) * DEN_W'(p_side.mag);
      d_side_r <= p_side;
    end
  end

  logic             q_vld;
  logic [QUO_W-1:0] q_quo;
  logic             q_ovf;
  side_t            q_side;

  tmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .in_den   (d_den_r),
    .in_power (power_r),
    .in_side  (d_side_r),
    .out_vld  (q_vld),
    .out_quo  (q_quo),
    .out_ovf  (q_ovf),
    .out_side (q_side)
  );

  // Clipping and sign. A negative flow may reach one count further than a positive one.
  logic [QUO_W-1:0]  limit;
  logic              fin_sat;
  logic [QUO_W-1:0]  fin_mag;
  logic [FLOW_W-1:0] fin_flow;

  always_comb begin
    limit   = q_side.neg ? FLOW_NEG_MAX : FLOW_POS_MAX;
    fin_sat = !q_side.zero && (q_ovf || (q_quo > limit));
    fin_mag = fin_sat ? limit : q_quo;
    if (q_side.zero) begin
      fin_flow = '0;
    end else if (q_side.neg) begin
      fin_flow = FLOW_W'(-fin_mag);
    end else begin
      fin_flow = fin_mag[FLOW_W-1:0];
    end
  end

  // Output register with one skid entry behind it.
  logic              out_vld_r;
  logic [FLOW_W-1:0] out_flow_r;
  logic              out_zero_r;
  logic              out_sat_r;
  logic [FLOW_W-1:0] skid_flow_r;
  logic              skid_zero_r;
  logic              skid_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_ch.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= q_vld;
      end
    end else if (q_vld && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_flow_r <= skid_flow_r;
        out_zero_r <= skid_zero_r;
        out_sat_r  <= skid_sat_r;
      end else begin
        out_flow_r <= fin_flow;
        out_zero_r <= q_side.zero;
        out_sat_r  <= fin_sat;
      end
    end else if (en) begin
      skid_flow_r <= fin_flow;
      skid_zero_r <= q_side.zero;
      skid_sat_r  <= fin_sat;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.mass_flow = out_flow_r;
  assign out_ch.zero_flow = out_zero_r;
  assign out_ch.saturated = out_sat_r;

`ifndef SYNTHESIS
  // A result in the deadband never carries flow or a clip flag.
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_zero_r |-> (out_flow_r == '0) && !out_sat_r)
    else $error("zero flow result with nonzero flow or clip flag");

  // A clipped result sits exactly at one of the range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sat_r |-> (out_flow_r == 20'h7FFFF) || (out_flow_r == 20'h80000))
    else $error("clipped result not at a range limit");

  // The skid entry only holds a result while the output register is full.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry occupied with empty output register");

  // The skid entry fills only after the result channel refused a result.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ch.ready))
    else $error("skid entry filled without backpressure");
`endif

endmodule
